### rtl/ida_pkg.sv
package ida_pkg;

    // Field widths of the item and result channels
    localparam int IN_VALUE_W     = 64;
    localparam int CHAR_W         = 6;
    localparam int LEN_W          = 5;
    localparam int DEF_VALUE_WIDTH = 64;

    // Character codes
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0] CHAR_NONE  = 6'd0;

    // Flags that travel with a converted magnitude
    typedef struct packed {
        logic neg;
        logic len_only;
    } t_conv_ctl;

    // Output sequencer states
    typedef enum logic [2:0] {
        E_IDLE,
        E_SKIP,
        E_LEN,
        E_SIGN,
        E_DIGIT
    } t_emit_state;

    // Decimal digits needed for a width-bit unsigned word: floor(w*log10(2))+1
    function automatic int num_digits(input int width);
        return ((width * 1233) >> 12) + 1;
    endfunction

    // Shift-add-3 correction of one BCD digit
    function automatic logic [3:0] dabble_adj(input logic [3:0] d);
        return (d >= 4'd5) ? d + 4'd3 : d;
    endfunction

endpackage

### rtl/ida_in_if.sv
interface ida_in_if;
    import ida_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [IN_VALUE_W-1:0] value;
    logic                  is_signed;
    logic                  length_only;

    modport source (output valid, value, is_signed, length_only, input ready);
    modport sink   (input valid, value, is_signed, length_only, output ready);
endinterface

### rtl/ida_out_if.sv
interface ida_out_if;
    import ida_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic [LEN_W-1:0]  text_length;
    logic              last;

    modport source (output valid, char_code, text_length, last, input ready);
    modport sink   (input valid, char_code, text_length, last, output ready);
endinterface

### rtl/ida_conv.sv
module ida_conv #(
    parameter int VALUE_WIDTH = ida_pkg::DEF_VALUE_WIDTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [ida_pkg::IN_VALUE_W-1:0]     i_value,
    input  logic                               i_is_signed,
    input  logic                               i_length_only,
    output logic                               o_ready,
    output logic                               o_valid,
    input  logic                               i_take,
    output logic [4*ida_pkg::num_digits(VALUE_WIDTH)-1:0] o_bcd,
    output ida_pkg::t_conv_ctl                 o_ctl
);
    import ida_pkg::*;

    localparam int ND   = num_digits(VALUE_WIDTH);
    localparam int CntW = $clog2(VALUE_WIDTH + 1);

    logic [VALUE_WIDTH-1:0] r_mag, n_mag;
    logic [4*ND-1:0]        r_bcd, n_bcd;
    logic [CntW-1:0]        r_cnt, n_cnt;
    logic                   r_busy, n_busy;
    logic                   r_full, n_full;
    t_conv_ctl              r_ctl, n_ctl;

    logic [VALUE_WIDTH-1:0] word;
    logic                   neg;
    logic [4*ND-1:0]        adj;

    assign word = i_value[VALUE_WIDTH-1:0];
    assign neg  = i_is_signed & word[VALUE_WIDTH-1];

    // add-3 correction on every digit in parallel
    always_comb begin
        for (int i = 0; i < ND; i++) begin
            adj[4*i +: 4] = dabble_adj(r_bcd[4*i +: 4]);
        end
    end

    // load, then one magnitude bit per cycle MSB first
    always_comb begin
        n_mag  = r_mag;
        n_bcd  = r_bcd;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_full = r_full;
        n_ctl  = r_ctl;
        if (i_take) begin
            n_full = 1'b0;
        end
        if (i_start) begin
            n_mag        = neg ? (~word + 1'b1) : word;
            n_bcd        = '0;
            n_cnt        = CntW'(VALUE_WIDTH);
            n_busy       = 1'b1;
            n_ctl.neg      = neg;
            n_ctl.len_only = i_length_only;
        end else if (r_busy) begin
            n_bcd = {adj[4*ND-2:0], r_mag[VALUE_WIDTH-1]};
            n_mag = r_mag << 1;
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CntW'(1)) begin
                n_busy = 1'b0;
                n_full = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_full <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_full <= n_full;
        end
        r_mag <= n_mag;
        r_bcd <= n_bcd;
        r_cnt <= n_cnt;
        r_ctl <= n_ctl;
    end

    assign o_ready = ~r_busy & ~r_full;
    assign o_valid = r_full;
    assign o_bcd   = r_bcd;
    assign o_ctl   = r_ctl;
endmodule

### rtl/ida_emit.sv
module ida_emit #(
    parameter int VALUE_WIDTH = ida_pkg::DEF_VALUE_WIDTH
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_valid,
    output logic                                          o_take,
    input  logic [4*ida_pkg::num_digits(VALUE_WIDTH)-1:0] i_bcd,
    input  ida_pkg::t_conv_ctl                            i_ctl,
    ida_out_if.source                                     o_char
);
    import ida_pkg::*;

    localparam int ND  = num_digits(VALUE_WIDTH);
    localparam int NdW = $clog2(ND + 1);

    t_emit_state      r_state, n_state;
    logic [4*ND-1:0]  r_bcd, n_bcd;
    logic [NdW-1:0]   r_ndig, n_ndig;
    logic [LEN_W-1:0] r_len, n_len;
    t_conv_ctl        r_ctl, n_ctl;

    logic [3:0]       top_digit;

    assign top_digit = r_bcd[4*ND-1 -: 4];

    // Strip leading zeros a digit a cycle, then send each character or the length
    always_comb begin
        n_state = r_state;
        n_bcd   = r_bcd;
        n_ndig  = r_ndig;
        n_len   = r_len;
        n_ctl   = r_ctl;
        o_take  = 1'b0;
        o_char.valid       = 1'b0;
        o_char.char_code   = CHAR_NONE;
        o_char.text_length = r_len;
        o_char.last        = 1'b0;
        case (r_state)
            E_IDLE: begin
                if (i_valid) begin
                    o_take  = 1'b1;
                    n_bcd   = i_bcd;
                    n_ctl   = i_ctl;
                    n_ndig  = NdW'(ND);
                    n_state = E_SKIP;
                end
            end
            E_SKIP: begin
                if (top_digit == 4'd0 && r_ndig > NdW'(1)) begin
                    n_bcd  = r_bcd << 4;
                    n_ndig = r_ndig - 1'b1;
                end else begin
                    n_len = LEN_W'(r_ndig) + LEN_W'(r_ctl.neg);
                    if (r_ctl.len_only) begin
                        n_state = E_LEN;
                    end else if (r_ctl.neg) begin
                        n_state = E_SIGN;
                    end else begin
                        n_state = E_DIGIT;
                    end
                end
            end
            E_LEN: begin
                o_char.valid = 1'b1;
                o_char.last  = 1'b1;
                if (o_char.ready) begin
                    n_state = E_IDLE;
                end
            end
            E_SIGN: begin
                o_char.valid     = 1'b1;
                o_char.char_code = CHAR_MINUS;
                if (o_char.ready) begin
                    n_state = E_DIGIT;
                end
            end
            E_DIGIT: begin
                o_char.valid     = 1'b1;
                o_char.char_code = CHAR_ZERO + {2'b00, top_digit};
                o_char.last      = (r_ndig == NdW'(1));
                if (o_char.ready) begin
                    n_bcd  = r_bcd << 4;
                    n_ndig = r_ndig - 1'b1;
                    if (r_ndig == NdW'(1)) begin
                        n_state = E_IDLE;
                    end
                end
            end
            default: begin
                n_state = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_bcd  <= n_bcd;
        r_ndig <= n_ndig;
        r_len  <= n_len;
        r_ctl  <= n_ctl;
    end
endmodule

### rtl/integer_to_decimal_ascii_top.sv
// The item transfer starts the bit-serial converter; the sequencer then takes the result
// and strips leading zeros, one per cycle (up to ND-1, ND = 20 at 64 bits), then sends
// one character per cycle while the receiver is ready.
// The item rate is set by the bit-serial converter while the sequencer keeps up; the converter
// takes the next item while the sequencer sends characters.
// Reset: synchronous active-low i_rst_n clears converter and sequencer control.
module integer_to_decimal_ascii_top #(
    parameter int VALUE_WIDTH = ida_pkg::DEF_VALUE_WIDTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ida_in_if.sink    i_item,
    ida_out_if.source o_char
);
    import ida_pkg::*;

    localparam int ND = num_digits(VALUE_WIDTH);

    logic            conv_ready;
    logic            conv_valid;
    logic            conv_take;
    logic [4*ND-1:0] conv_bcd;
    t_conv_ctl       conv_ctl;

    // item transfer starts the converter
    assign i_item.ready = conv_ready;

    ida_conv #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_conv (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_item.valid & conv_ready),
        .i_value       (i_item.value),
        .i_is_signed   (i_item.is_signed),
        .i_length_only (i_item.length_only),
        .o_ready       (conv_ready),
        .o_valid       (conv_valid),
        .i_take        (conv_take),
        .o_bcd         (conv_bcd),
        .o_ctl         (conv_ctl)
    );

    ida_emit #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (conv_valid),
        .o_take  (conv_take),
        .i_bcd   (conv_bcd),
        .i_ctl   (conv_ctl),
        .o_char  (o_char)
    );
endmodule

### tb/tb_integer_to_decimal_ascii_top.sv
`timescale 1ns / 100ps

module tb_integer_to_decimal_ascii_top;
    import ida_pkg::*;

    localparam int CLK_PERIOD = 12;
    localparam int VW         = DEF_VALUE_WIDTH;
    localparam int MAX_CHARS  = 20;
    localparam int HOLD_LEN   = 400;
    localparam int DRAIN_LEN  = 200;
    localparam int LIMIT_CYC  = 600_000;
    localparam logic [63:0] VW_MASK = {64{1'b1}} >> (64 - VW);

    // One number to convert
    typedef struct {
        logic [63:0] value;
        logic        sgn;
        logic        lonly;
    } t_number;

    // One expected character of the decimal text
    typedef struct {
        logic [CHAR_W-1:0] code;
        logic [LEN_W-1:0]  len;
        logic              last;
    } t_text_char;

    logic i_clk;
    logic i_rst_n;

    ida_in_if  item_if ();
    ida_out_if char_if ();

    t_number    pending_numbers[$];
    t_text_char expected_chars[$];
    t_number    drive_num;
    t_text_char got_char;

    int  send_idle_pct;
    int  recv_idle_pct;
    int  numbers_taken;
    int  fail_count;
    logic in_took;
    logic rx_hold;

    integer_to_decimal_ascii_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_if),
        .o_char  (char_if)
    );

    // Clock and reset
    initial begin
        i_clk = 1'b0;
    end

    always begin
        #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        i_rst_n             = 1'b0;
        item_if.valid       = 1'b0;
        item_if.value       = '0;
        item_if.is_signed   = 1'b0;
        item_if.length_only = 1'b0;
        char_if.ready       = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Expected text for one number, pushed in output order
    function automatic void predict_text(input logic [63:0] value, input logic sgn,
                                         input logic lonly);
        logic [63:0] word;
        logic [63:0] mag;
        logic        neg;
        logic [3:0]  digs [0:MAX_CHARS-1];
        int          nd;
        int          total;
        int          pos;
        t_text_char  c;

        word = value & VW_MASK;
        neg  = sgn && word[VW-1];
        mag  = neg ? ((~word + 64'd1) & VW_MASK) : word;
        nd   = 0;
        do begin
            digs[nd] = 4'(mag % 64'd10);
            mag      = mag / 64'd10;
            nd++;
        end while (mag != 0 && nd < MAX_CHARS);
        total = nd + (neg ? 1 : 0);

        // length-only: a single marker result
        if (lonly) begin
            c.code = CHAR_NONE;
            c.len  = LEN_W'(total);
            c.last = 1'b1;
            expected_chars.push_back(c);
            return;
        end

        pos = 0;
        if (neg) begin
            c.code = CHAR_MINUS;
            c.len  = LEN_W'(total);
            c.last = (total == 1);
            expected_chars.push_back(c);
            pos = 1;
        end
        for (int k = nd - 1; k >= 0; k--) begin
            c.code = CHAR_ZERO + CHAR_W'(digs[k]);
            c.len  = LEN_W'(total);
            c.last = (pos == total - 1);
            expected_chars.push_back(c);
            pos++;
        end
    endfunction

    // Item driver: new transfer offered at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            item_if.valid <= 1'b0;
        end else if (!item_if.valid || in_took) begin
            if (pending_numbers.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                drive_num = pending_numbers.pop_front();
                item_if.valid       <= 1'b1;
                item_if.value       <= drive_num.value;
                item_if.is_signed   <= drive_num.sgn;
                item_if.length_only <= drive_num.lonly;
            end else begin
                item_if.valid <= 1'b0;
            end
        end
    end

    // Character receiver backpressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            char_if.ready <= 1'b0;
        end else if (rx_hold) begin
            char_if.ready <= 1'b0;
        end else begin
            char_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Long receiver hold-off once traffic is flowing, so the input stalls
    initial begin
        rx_hold = 1'b0;
        while (numbers_taken < 40) @(negedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_LEN) @(negedge i_clk);
        rx_hold <= 1'b0;
    end

    // Monitor: predict on item transfer, check on character transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_took <= 1'b0;
        end else begin
            in_took <= item_if.valid && item_if.ready;
            if (item_if.valid && item_if.ready) begin
                predict_text(item_if.value, item_if.is_signed, item_if.length_only);
                numbers_taken++;
            end
            if (char_if.valid && char_if.ready) begin
                if (expected_chars.size() == 0) begin
                    $error("unexpected character: char_code %0d text_length %0d last %0b",
                           char_if.char_code, char_if.text_length, char_if.last);
                    fail_count++;
                end else begin
                    got_char = expected_chars.pop_front();
                    if (char_if.char_code !== got_char.code) begin
                        $error("char_code: expected %0d, got %0d",
                               got_char.code, char_if.char_code);
                        fail_count++;
                    end
                    if (char_if.text_length !== got_char.len) begin
                        $error("text_length: expected %0d, got %0d",
                               got_char.len, char_if.text_length);
                        fail_count++;
                    end
                    if (char_if.last !== got_char.last) begin
                        $error("last: expected %0b, got %0b", got_char.last, char_if.last);
                        fail_count++;
                    end
                end
            end
        end
    end

    task automatic add_number(input logic [63:0] value, input logic sgn, input logic lonly);
        t_number n;
        n.value = value;
        n.sgn   = sgn;
        n.lonly = lonly;
        pending_numbers.push_back(n);
    endtask

    // Random number biased toward every text length and the sign edges
    task automatic add_random_number();
        logic [63:0] v;
        logic [63:0] p;
        logic        sgn;
        int          pick;

        v    = {$urandom(), $urandom()};
        sgn  = $urandom_range(0, 1);
        pick = $urandom_range(0, 9);
        if (pick >= 4 && pick <= 6) begin
            v = v >> (64 - $urandom_range(1, 64));
        end else if (pick == 7) begin
            // around a power of ten
            p = 64'd1;
            repeat ($urandom_range(0, 19)) p = p * 64'd10;
            v = p + 64'($signed($urandom_range(0, 2)) - 1);
        end else if (pick == 8) begin
            // small negative
            v   = ~(v >> (64 - $urandom_range(1, 63))) + 64'd1;
            sgn = 1'b1;
        end else if (pick == 9) begin
            case ($urandom_range(0, 3))
                0: v = 64'h8000_0000_0000_0000;
                1: v = 64'h7FFF_FFFF_FFFF_FFFF;
                2: v = '1;
                default: v = '0;
            endcase
        end
        add_number(v, sgn, $urandom_range(0, 3) == 0);
    endtask

    task automatic wait_all_sent();
        while (pending_numbers.size() != 0 || item_if.valid) @(posedge i_clk);
    endtask

    // Stimulus
    initial begin
        send_idle_pct = 7;
        recv_idle_pct = 66;
        numbers_taken = 0;
        fail_count    = 0;
        @(posedge i_rst_n);

        // directed corners
        add_number(64'd0, 1'b0, 1'b0);
        add_number(64'd0, 1'b1, 1'b0);
        add_number(64'd0, 1'b0, 1'b1);
        add_number(64'd1, 1'b0, 1'b0);
        add_number(64'd9, 1'b1, 1'b0);
        add_number(64'd10, 1'b0, 1'b0);
        add_number('1, 1'b0, 1'b0);
        add_number('1, 1'b1, 1'b0);
        add_number(64'h8000_0000_0000_0000, 1'b1, 1'b0);
        add_number(64'h8000_0000_0000_0000, 1'b0, 1'b0);
        add_number(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b0);
        add_number(64'd10_000_000_000_000_000_000, 1'b0, 1'b0);
        add_number(64'd9_999_999_999_999_999_999, 1'b0, 1'b0);
        add_number(-64'sd9, 1'b1, 1'b0);
        add_number(-64'sd10, 1'b1, 1'b0);
        add_number(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0);
        add_number(64'h5555_5555_5555_5555, 1'b1, 1'b0);
        add_number('1, 1'b0, 1'b1);
        add_number('1, 1'b1, 1'b1);
        add_number(64'h8000_0000_0000_0000, 1'b1, 1'b1);
        add_number(64'd9, 1'b0, 1'b1);

        repeat (140) add_random_number();
        wait_all_sent();

        send_idle_pct = 66;
        recv_idle_pct = 7;
        repeat (150) add_random_number();
        wait_all_sent();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (150) add_random_number();
        wait_all_sent();

        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_LEN) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("integer_to_decimal_ascii_top regression: pass");
        end else begin
            $display("integer_to_decimal_ascii_top regression: fail");
        end
        $finish;
    end

    // Timeout
    initial begin
        #(LIMIT_CYC * CLK_PERIOD);
        $display("integer_to_decimal_ascii_top regression: fail");
        $finish;
    end

endmodule
